/* sv/assert_macros.svh */
// Assertion macros for the RTL of the sort engine; the sequencer includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/rpcs_pkg.sv */
// Package with the types and constants of the random pair compare-swap sort engine.
`timescale 1ns / 1ps
package rpcs_pkg;

    localparam int REQ_W  = 2;
    localparam int POS_W  = 10;
    localparam int VAL_W  = 16;
    localparam int LEN_W  = 11;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_LOAD = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SWAP = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

    // Register index, taken from the word address bit of paddr.
    localparam logic REG_ACTIVE_LENGTH = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RD_B,
        S_CMP,
        S_WR_B,
        S_RD_CAP,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [VAL_W-1:0] read_value;
        logic             did_swap;
        logic             is_sorted;
    } t_result;

endpackage

/* sv/rpcs_mem.sv */
// Element store: one write port and one read port with registered read data.
`timescale 1ns / 1ps
module rpcs_mem #(
    parameter int DEPTH = 1024,
    parameter int W     = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/rpcs_cmp.sv */
// Shared value comparator used for both the pair decision and the sortedness scan.
`timescale 1ns / 1ps
module rpcs_cmp #(
    parameter int W = 16
) (
    input  logic [W-1:0] i_lhs,
    input  logic [W-1:0] i_rhs,
    output logic         o_gt
);

    assign o_gt = (i_lhs > i_rhs);

endmodule

/* sv/rpcs_ctrl.sv */
// Sequencer that runs one request against the element store and then scans for order.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rpcs_ctrl #(
    parameter int DEPTH      = 1024,
    parameter int VALUE_BITS = 16,
    parameter int AW         = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [rpcs_pkg::LEN_W-1:0] i_cfg_len,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [rpcs_pkg::REQ_W-1:0] i_req_type,
    input  logic [rpcs_pkg::POS_W-1:0] i_first_pos,
    input  logic [rpcs_pkg::POS_W-1:0] i_second_pos,
    input  logic [rpcs_pkg::VAL_W-1:0] i_load_value,
    output logic                      o_done,
    input  logic                      i_take,
    output rpcs_pkg::t_result         o_res,
    output logic                      o_mem_we,
    output logic [AW-1:0]             o_mem_waddr,
    output logic [VALUE_BITS-1:0]     o_mem_wdata,
    output logic                      o_mem_re,
    output logic [AW-1:0]             o_mem_raddr,
    input  logic [VALUE_BITS-1:0]     i_mem_rdata
);
    import rpcs_pkg::*;

    localparam int LW = $clog2(DEPTH + 1);
    localparam int KW = (LW > LEN_W) ? LW : LEN_W;

    t_state                r_state, n_state;
    logic [REQ_W-1:0]      r_req, n_req;
    logic [POS_W-1:0]      r_p1, n_p1;
    logic [POS_W-1:0]      r_p2, n_p2;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic [VALUE_BITS-1:0] r_a, n_a;
    logic [VALUE_BITS-1:0] r_rd, n_rd;
    logic [VALUE_BITS-1:0] r_prev, n_prev;
    logic                  r_swapped, n_swapped;
    logic                  r_sorted, n_sorted;
    logic [LW-1:0]         r_idx, n_idx;

    logic [LW-1:0]         eff_len;
    logic                  p1_ok;
    logic                  p2_ok;
    logic [VALUE_BITS-1:0] cmp_lhs;
    logic [VALUE_BITS-1:0] cmp_rhs;
    logic                  cmp_gt;

    // A length of zero or beyond the store acts as the full store.
    always_comb begin
        if (i_cfg_len == '0 || KW'(i_cfg_len) > KW'(DEPTH)) begin
            eff_len = LW'(DEPTH);
        end else begin
            eff_len = LW'(i_cfg_len);
        end
    end

    assign p1_ok = (KW'(r_p1) < KW'(eff_len));
    assign p2_ok = (KW'(r_p2) < KW'(eff_len));

    // The pair decision orders the operands by position so that one
    // greater-than covers both directions.
    always_comb begin
        if (r_state == S_CMP) begin
            if (r_p1 < r_p2) begin
                cmp_lhs = r_a;
                cmp_rhs = i_mem_rdata;
            end else begin
                cmp_lhs = i_mem_rdata;
                cmp_rhs = r_a;
            end
        end else begin
            cmp_lhs = r_prev;
            cmp_rhs = i_mem_rdata;
        end
    end

    rpcs_cmp #(
        .W(VALUE_BITS)
    ) u_cmp (
        .i_lhs(cmp_lhs),
        .i_rhs(cmp_rhs),
        .o_gt (cmp_gt)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_req)
                    REQ_SWAP: begin
                        if (p1_ok && p2_ok && r_p1 != r_p2) begin
                            n_state = S_RD_B;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    REQ_READ: begin
                        n_state = p1_ok ? S_RD_CAP : S_SCAN;
                    end
                    default: begin
                        n_state = S_SCAN;
                    end
                endcase
            end
            S_RD_B:   n_state = S_CMP;
            S_CMP:    n_state = cmp_gt ? S_WR_B : S_SCAN;
            S_WR_B:   n_state = S_SCAN;
            S_RD_CAP: n_state = S_SCAN;
            S_SCAN: begin
                if (r_idx == eff_len) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_req       = r_req;
        n_p1        = r_p1;
        n_p2        = r_p2;
        n_val       = r_val;
        n_a         = r_a;
        n_rd        = r_rd;
        n_prev      = r_prev;
        n_swapped   = r_swapped;
        n_sorted    = r_sorted;
        n_idx       = r_idx;
        o_mem_we    = 1'b0;
        o_mem_waddr = AW'(r_p1);
        o_mem_wdata = r_val;
        o_mem_re    = 1'b0;
        o_mem_raddr = AW'(r_p1);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req     = i_req_type;
                    n_p1      = i_first_pos;
                    n_p2      = i_second_pos;
                    n_val     = VALUE_BITS'(i_load_value);
                    n_rd      = '0;
                    n_swapped = 1'b0;
                    n_sorted  = 1'b1;
                    n_idx     = '0;
                end
            end
            S_EXEC: begin
                case (r_req)
                    REQ_LOAD: o_mem_we = p1_ok;
                    REQ_SWAP: o_mem_re = p1_ok && p2_ok && r_p1 != r_p2;
                    REQ_READ: o_mem_re = p1_ok;
                    default: ;
                endcase
            end
            S_RD_B: begin
                n_a         = i_mem_rdata;
                o_mem_re    = 1'b1;
                o_mem_raddr = AW'(r_p2);
            end
            S_CMP: begin
                if (cmp_gt) begin
                    o_mem_we    = 1'b1;
                    o_mem_wdata = i_mem_rdata;
                    n_swapped   = 1'b1;
                end
            end
            S_WR_B: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = AW'(r_p2);
                o_mem_wdata = r_a;
            end
            S_RD_CAP: begin
                n_rd = i_mem_rdata;
            end
            S_SCAN: begin
                // Reads go out one per cycle; the data of the previous read
                // arrives while r_idx is nonzero.
                if (r_idx != eff_len) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = r_idx[AW-1:0];
                    n_idx       = r_idx + LW'(1);
                end
                if (r_idx != '0) begin
                    n_prev = i_mem_rdata;
                    if (r_idx >= LW'(2) && cmp_gt) begin
                        n_sorted = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_in_ready       = (r_state == S_IDLE);
        o_done           = (r_state == S_DONE);
        o_res.read_value = VAL_W'(r_rd);
        o_res.did_swap   = r_swapped;
        o_res.is_sorted  = r_sorted;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_req     <= REQ_LOAD;
            r_swapped <= 1'b0;
            r_sorted  <= 1'b1;
            r_idx     <= '0;
        end else begin
            r_state   <= n_state;
            r_req     <= n_req;
            r_swapped <= n_swapped;
            r_sorted  <= n_sorted;
            r_idx     <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1   <= n_p1;
        r_p2   <= n_p2;
        r_val  <= n_val;
        r_a    <= n_a;
        r_rd   <= n_rd;
        r_prev <= n_prev;
    end

    `ASSERT_CLK(a_scan_no_write, i_clk, i_rst_n, (r_state == S_SCAN) |-> !o_mem_we, "store written during the order scan")
    `ASSERT_CLK(a_scan_idx_bound, i_clk, i_rst_n, (r_state == S_SCAN) |-> (r_idx <= eff_len), "scan index ran past the active length")
    `ASSERT_CLK(a_swap_only_pair, i_clk, i_rst_n, r_swapped |-> (r_req == REQ_SWAP), "swap flagged for a request that is not a pair")
    `ASSERT_CLK(a_done_after_scan, i_clk, i_rst_n, (r_state == S_DONE && $past(r_state) != S_DONE) |-> ($past(r_state) == S_SCAN), "result finished without a scan")

endmodule

/* sv/random_pair_compare_swap_sort.sv */
// Top level of the random pair compare-swap sort engine: register port, sequencer, result register.
//
// Channel   Direction  Handshake                        Carries
// in        input      i_in_valid / o_in_ready           req_type, first_pos, second_pos, load_value
// out       output     o_out_valid / i_out_ready         read_value, did_swap, is_sorted
// config    input      psel, penable, pwrite, pready     active_length at byte address 0
//
// After acceptance a load or an ignored request goes from execute straight to the order scan; a read
// adds a capture step, a pair adds a second read and a compare, and a pair that is exchanged also a
// write-back. The order scan reads one element per cycle from one read port over the effective length.
// Reset is synchronous and active low; the store itself is not cleared.
// A new item is taken while a finished result still waits in the output register;
// a second result waits in the sequencer until the output register frees up.
`timescale 1ns / 1ps
module random_pair_compare_swap_sort #(
    parameter int DEPTH      = 1024,
    parameter int VALUE_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [rpcs_pkg::REQ_W-1:0]   i_req_type,
    input  logic [rpcs_pkg::POS_W-1:0]   i_first_pos,
    input  logic [rpcs_pkg::POS_W-1:0]   i_second_pos,
    input  logic [rpcs_pkg::VAL_W-1:0]   i_load_value,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [rpcs_pkg::VAL_W-1:0]   o_read_value,
    output logic                         o_did_swap,
    output logic                         o_is_sorted,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rpcs_pkg::ADDR_W-1:0]  paddr,
    input  logic [rpcs_pkg::DATA_W-1:0]  pwdata,
    output logic [rpcs_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import rpcs_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [LEN_W-1:0]      r_len;
    logic                  r_out_valid;
    t_result               r_res;
    logic                  done;
    logic                  take;
    t_result               res;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [VALUE_BITS-1:0] mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [VALUE_BITS-1:0] mem_rdata;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_ACTIVE_LENGTH) begin
            r_len <= pwdata[LEN_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == REG_ACTIVE_LENGTH) begin
            prdata = DATA_W'(r_len);
        end else begin
            prdata = '0;
        end
    end

    rpcs_ctrl #(
        .DEPTH     (DEPTH),
        .VALUE_BITS(VALUE_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_len   (r_len),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .i_first_pos (i_first_pos),
        .i_second_pos(i_second_pos),
        .i_load_value(i_load_value),
        .o_done      (done),
        .i_take      (take),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    rpcs_mem #(
        .DEPTH(DEPTH),
        .W    (VALUE_BITS)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_re   (mem_re),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    // The result moves out once the output register is empty or being emptied.
    assign take = done && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_res.read_value;
    assign o_did_swap   = r_res.did_swap;
    assign o_is_sorted  = r_res.is_sorted;

endmodule
